@@ rtl/prefixed_number_literal_recognizer_top_macros.svh @@
// Assertion macros shared by the recogniser RTL.
`ifndef PREFIXED_NUMBER_LITERAL_RECOGNIZER_TOP_MACROS_SVH
`define PREFIXED_NUMBER_LITERAL_RECOGNIZER_TOP_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define PNLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define PNLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pnlr_pkg.sv @@
// Shared types and constants for the prefixed number literal recogniser.
package pnlr_pkg;

	localparam int unsigned ValueWidthDefault = 64;
	localparam int unsigned IntWidth          = 64;
	localparam int unsigned QueueDepth        = 2;

	localparam logic [7:0] CharDec   = 8'h23; // '#'
	localparam logic [7:0] CharHex   = 8'h24; // '$'
	localparam logic [7:0] CharBin   = 8'h25; // '%'
	localparam logic [7:0] CharReal  = 8'h26; // '&'
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharPlus  = 8'h2B;
	localparam logic [7:0] CharPoint = 8'h2E;
	localparam logic [7:0] CharExp   = 8'h65; // lower-case 'e' only
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharOne   = 8'h31;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharLowA  = 8'h61;
	localparam logic [7:0] CharLowF  = 8'h66;
	localparam logic [7:0] CharUpA   = 8'h41;
	localparam logic [7:0] CharUpF   = 8'h46;

	typedef enum logic [5:0] {
		FORM_START  = 6'b000001,
		FORM_DEC    = 6'b000010,
		FORM_HEX    = 6'b000100,
		FORM_BIN    = 6'b001000,
		FORM_REAL   = 6'b010000,
		FORM_REJECT = 6'b100000
	} form_t;

	typedef enum logic [1:0] {
		KIND_NAN   = 2'd0,
		KIND_INT   = 2'd1,
		KIND_REAL  = 2'd2,
		KIND_RANGE = 2'd3
	} kind_t;

	typedef struct packed {
		form_t      prefix;
		logic       dec_digit;
		logic       hex_digit;
		logic       bin_digit;
		logic [3:0] digit;
		logic       minus;
		logic       plus;
		logic       point;
		logic       exp_mark;
		logic       last;
	} char_class_t;

	typedef struct packed {
		logic        valid;
		char_class_t item;
	} q_entry_t;

endpackage

@@ rtl/pnlr_if.sv @@
// Request channel interfaces: token characters in, classified literals out.
interface pnlr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic       last_char;

	modport source (output valid, token_char, last_char, input ready);
	modport sink (input valid, token_char, last_char, output ready);
endinterface

interface pnlr_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    literal_kind;
	logic [pnlr_pkg::IntWidth-1:0] integer_value;

	modport source (output valid, literal_kind, integer_value, input ready);
	modport sink (input valid, literal_kind, integer_value, output ready);
endinterface

@@ rtl/pnlr_front.sv @@
// Front end: takes a character request and decodes it into a character class.
module pnlr_front (
	pnlr_char_if.sink          chars,
	input  logic               push_ready,
	output pnlr_pkg::q_entry_t push
);
	import pnlr_pkg::*;

	char_class_t cls;
	logic [7:0]  ch;
	logic        is_dec;
	logic        is_low;
	logic        is_up;

	assign ch     = chars.token_char;
	assign is_dec = (ch >= CharZero) && (ch <= CharNine);
	assign is_low = (ch >= CharLowA) && (ch <= CharLowF);
	assign is_up  = (ch >= CharUpA) && (ch <= CharUpF);

	always_comb begin
		unique case (ch)
			CharDec:  cls.prefix = FORM_DEC;
			CharHex:  cls.prefix = FORM_HEX;
			CharBin:  cls.prefix = FORM_BIN;
			CharReal: cls.prefix = FORM_REAL;
			default:  cls.prefix = FORM_REJECT;
		endcase
		cls.dec_digit = is_dec;
		cls.hex_digit = is_dec || is_low || is_up;
		cls.bin_digit = (ch == CharZero) || (ch == CharOne);
		// letters a-f / A-F sit at low nibble 1..6
		cls.digit     = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
		cls.minus     = (ch == CharMinus);
		cls.plus      = (ch == CharPlus);
		cls.point     = (ch == CharPoint);
		cls.exp_mark  = (ch == CharExp);
		cls.last      = chars.last_char;
	end

	assign push.valid  = chars.valid;
	assign push.item   = cls;
	assign chars.ready = push_ready;

endmodule

@@ rtl/pnlr_queue.sv @@
// Short queue of decoded characters between the front and back ends.
`include "prefixed_number_literal_recognizer_top_macros.svh"
module pnlr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  pnlr_pkg::q_entry_t push,
	output logic               push_ready,
	output pnlr_pkg::q_entry_t head,
	input  logic               pop
);
	import pnlr_pkg::*;

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	char_class_t     mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(QueueDepth));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= CntW'(count_q + 1'b1);
				2'b01:   count_q <= CntW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	`PNLR_ASSERT(a_pop_nonempty, !pop || head.valid, "pop from empty queue")
	`PNLR_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "queue count overflow")

endmodule

@@ rtl/pnlr_back.sv @@
// Back end: runs the token state, accumulates the value and holds the result.
`include "prefixed_number_literal_recognizer_top_macros.svh"
module pnlr_back #(
	parameter int unsigned VALUE_WIDTH = pnlr_pkg::ValueWidthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pnlr_pkg::q_entry_t head,
	output logic               pop,
	pnlr_result_if.source      results
);
	import pnlr_pkg::*;

	localparam int unsigned AccW = VALUE_WIDTH + 4;

	form_t                  form_q, form_n;
	logic [1:0]             pos_q, pos_n;
	logic                   minus_q, minus_n;
	logic                   point_q, point_n;
	logic                   exp_q, exp_n;
	logic                   exps_q, exps_n;
	logic                   digit_q, digit_n;
	logic                   big_q, big_n;
	logic [VALUE_WIDTH-1:0] mag_q, mag_n;

	logic                   out_valid_q;
	kind_t                  out_kind_q;
	logic [VALUE_WIDTH-1:0] out_mag_q;
	logic                   out_neg_q;

	char_class_t            c;
	logic                   take;
	logic                   acc;
	logic [AccW-1:0]        mag_ext;
	logic [AccW-1:0]        scaled;
	logic [AccW-1:0]        sum;
	logic [AccW-1:0]        limit;
	logic                   over;
	kind_t                  kind_n;
	logic [VALUE_WIDTH-1:0] res_mag;
	logic                   res_neg;
	logic [VALUE_WIDTH-1:0] neg_val;

	assign c    = head.item;
	// a non-final character needs no room in the result register
	assign take = head.valid && (!c.last || !out_valid_q || results.ready);
	assign pop  = take;

	// radix step: x10 as shift-add, x16 and x2 as shifts
	always_comb begin
		mag_ext = AccW'(mag_q);
		unique case (form_q)
			FORM_HEX: scaled = mag_ext << 4;
			FORM_BIN: scaled = mag_ext << 1;
			default:  scaled = AccW'((mag_ext << 3) + (mag_ext << 1));
		endcase
		sum   = AccW'(scaled + AccW'(c.digit));
		limit = (form_q == FORM_DEC) ? (AccW'(1) << (VALUE_WIDTH - 1))
		                             : AccW'((AccW'(1) << VALUE_WIDTH) - 1'b1);
		over  = (sum > limit);
	end

	always_comb begin
		form_n  = form_q;
		minus_n = minus_q;
		point_n = point_q;
		exp_n   = exp_q;
		exps_n  = exps_q;
		digit_n = digit_q;
		big_n   = big_q;
		mag_n   = mag_q;
		acc     = 1'b0;
		unique case (form_q)
			FORM_START: form_n = c.prefix;
			FORM_DEC: begin
				if (c.dec_digit) acc = 1'b1;
				else if (c.minus && (pos_q == 2'd1) && !minus_q) minus_n = 1'b1;
				else form_n = FORM_REJECT;
			end
			FORM_HEX: begin
				if (c.hex_digit) acc = 1'b1;
				else form_n = FORM_REJECT;
			end
			FORM_BIN: begin
				if (c.bin_digit) acc = 1'b1;
				else form_n = FORM_REJECT;
			end
			FORM_REAL: begin
				priority if (c.dec_digit) digit_n = 1'b1;
				else if (c.minus && (pos_q == 2'd1)) minus_n = 1'b1;
				else if (c.point && !point_q) point_n = 1'b1;
				else if (c.exp_mark && !exp_q) exp_n = 1'b1;
				else if ((c.minus || c.plus) && exp_q && !exps_q) exps_n = 1'b1;
				else form_n = FORM_REJECT;
			end
			default: form_n = FORM_REJECT;
		endcase
		if (acc) begin
			digit_n = 1'b1;
			if (!big_q) begin
				if (over) big_n = 1'b1;
				else mag_n = sum[VALUE_WIDTH-1:0];
			end
		end
		pos_n = (pos_q == 2'd3) ? pos_q : 2'(pos_q + 2'd1);
	end

	// classification of the finished token
	always_comb begin
		kind_n  = KIND_NAN;
		res_mag = '0;
		res_neg = 1'b0;
		if (digit_n) begin
			if (form_n == FORM_REAL) begin
				kind_n = KIND_REAL;
			end else if ((form_n == FORM_HEX) || (form_n == FORM_BIN)) begin
				if (big_n) kind_n = KIND_RANGE;
				else begin
					kind_n  = KIND_INT;
					res_mag = mag_n;
				end
			end else if (form_n == FORM_DEC) begin
				// positive tops out one below the negative bound
				if (big_n || (!minus_n && mag_n[VALUE_WIDTH-1])) kind_n = KIND_RANGE;
				else begin
					kind_n  = KIND_INT;
					res_mag = mag_n;
					res_neg = minus_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q  <= FORM_START;
			pos_q   <= '0;
			minus_q <= 1'b0;
			point_q <= 1'b0;
			exp_q   <= 1'b0;
			exps_q  <= 1'b0;
			digit_q <= 1'b0;
			big_q   <= 1'b0;
			mag_q   <= '0;
		end else if (take) begin
			if (c.last) begin
				form_q  <= FORM_START;
				pos_q   <= '0;
				minus_q <= 1'b0;
				point_q <= 1'b0;
				exp_q   <= 1'b0;
				exps_q  <= 1'b0;
				digit_q <= 1'b0;
				big_q   <= 1'b0;
				mag_q   <= '0;
			end else begin
				form_q  <= form_n;
				pos_q   <= pos_n;
				minus_q <= minus_n;
				point_q <= point_n;
				exp_q   <= exp_n;
				exps_q  <= exps_n;
				digit_q <= digit_n;
				big_q   <= big_n;
				mag_q   <= mag_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && c.last) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && c.last) begin
			out_kind_q <= kind_n;
			out_mag_q  <= res_mag;
			out_neg_q  <= res_neg;
		end
	end

	// negation sits after the result register, off the accumulate path
	assign neg_val               = VALUE_WIDTH'('0 - out_mag_q);
	assign results.valid         = out_valid_q;
	assign results.literal_kind  = out_kind_q;
	assign results.integer_value = IntWidth'(out_neg_q ? neg_val : out_mag_q);

	`PNLR_ASSERT(a_big_has_digit, !big_q || digit_q, "overflow flag without a digit")
	`PNLR_ASSERT_NEXT(a_token_clears, take && c.last, (form_q == FORM_START) && (pos_q == 2'd0) && !digit_q, "state not cleared after token end")
	`PNLR_ASSERT(a_neg_is_int, !(out_valid_q && out_neg_q) || (out_kind_q == KIND_INT), "negated value on a non-integer result")

endmodule

@@ rtl/prefixed_number_literal_recognizer_top.sv @@
// The queue registers characters; the result register holds each token's result.
// Throughput: one character per cycle while results are taken, set by the back end's
// radix multiply-add (shift-add by 10, 16 or 2 plus overflow compare) done once per
// character. A two-entry character queue and a result register decouple the two sides.
// Reset (arst_n low, asynchronous): queue emptied, token state at start, no result.
module prefixed_number_literal_recognizer_top #(
	parameter int unsigned VALUE_WIDTH = pnlr_pkg::ValueWidthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	pnlr_char_if.sink     chars,
	pnlr_result_if.source results
);
	import pnlr_pkg::*;

	q_entry_t push;
	q_entry_t head;
	logic     push_ready;
	logic     pop;

	pnlr_front u_front (
		.chars      (chars),
		.push_ready (push_ready),
		.push       (push)
	);

	pnlr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	pnlr_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

@@ bench/prefixed_number_literal_recognizer_top_test.sv @@
// Self-checking bench for the prefixed number literal recogniser: directed tokens, then random.
module prefixed_number_literal_recognizer_top_test;
	import pnlr_pkg::*;

	localparam int unsigned VW          = ValueWidthDefault;
	localparam int          CHAR_TARGET = 1400;
	localparam int          LONG_HOLD   = 200;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          DIR_COUNT   = 11;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
	} literal_t;

	// One directed token: text right-aligned, first character in the top used byte.
	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] text;
		logic        given;
		kind_t       kind;
		logic [63:0] value;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pnlr_char_if   chars_if ();
	pnlr_result_if results_if ();

	prefixed_number_literal_recognizer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	dir_row_t dir_rows [DIR_COUNT] = '{
		'{4'd1, "#",              1'b1, KIND_NAN,  64'd0},
		'{4'd3, "$fF",            1'b1, KIND_INT,  64'hff},
		'{4'd3, "%10",            1'b1, KIND_INT,  64'd2},
		'{4'd3, "#-9",            1'b1, KIND_INT,  64'hffff_ffff_ffff_fff7},
		'{4'd5, "&1.e-",          1'b1, KIND_REAL, 64'd0},
		'{4'd1, "?",              1'b1, KIND_NAN,  64'd0},
		'{4'd2, "$g",             1'b1, KIND_NAN,  64'd0},
		'{4'd2, "#-",             1'b1, KIND_NAN,  64'd0},
		'{4'd2, {CharBin, 8'hff}, 1'b1, KIND_NAN,  64'd0},
		'{4'd1, 8'h00,            1'b1, KIND_NAN,  64'd0},
		'{4'd4, "#123",           1'b0, KIND_NAN,  64'd0}
	};

	// lexer state of the predictor
	form_t       lx_form;
	logic [1:0]  lx_pos;
	bit          lx_minus, lx_point, lx_exp, lx_exp_sign, lx_digit, lx_big;
	logic [63:0] lx_mag;

	literal_t   pending_literals [$];
	logic [7:0] tok_bytes [$];
	int         mismatch_count = 0;
	int         chars_sent = 0;
	bit         quiet_phase = 0;
	bit         long_hold_req = 0;

	function automatic logic [63:0] value_mask();
		return {64{1'b1}} >> (64 - VW);
	endfunction

	function automatic int digit_of(logic [7:0] c);
		if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
		if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
		if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
		return -1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic clear_lexer();
		lx_form = FORM_START;
		lx_pos = 2'd0;
		lx_minus = 0;
		lx_point = 0;
		lx_exp = 0;
		lx_exp_sign = 0;
		lx_digit = 0;
		lx_mag = 64'd0;
		lx_big = 0;
	endtask

	task automatic add_digit(int d, int base, logic [63:0] limit);
		lx_digit = 1;
		if (!lx_big) begin
			if (lx_mag > (limit - 64'(d)) / 64'(base))
				lx_big = 1;
			else
				lx_mag = lx_mag * 64'(base) + 64'(d);
		end
	endtask

	// Advance the predictor by one character; a literal comes out on the last one.
	task automatic classify_char(input logic [7:0] c, input logic fin,
			output bit has_lit, output literal_t lit);
		logic [63:0] dec_limit;
		int d;
		dec_limit = 64'd1 << (VW - 1);
		d = digit_of(c);
		case (lx_form)
			FORM_START: begin
				if (c == CharDec) lx_form = FORM_DEC;
				else if (c == CharHex) lx_form = FORM_HEX;
				else if (c == CharBin) lx_form = FORM_BIN;
				else if (c == CharReal) lx_form = FORM_REAL;
				else lx_form = FORM_REJECT;
			end
			FORM_DEC: begin
				if (d >= 0 && d <= 9) add_digit(d, 10, dec_limit);
				else if (c == CharMinus && lx_pos == 2'd1 && !lx_minus) lx_minus = 1;
				else lx_form = FORM_REJECT;
			end
			FORM_HEX: begin
				if (d >= 0) add_digit(d, 16, value_mask());
				else lx_form = FORM_REJECT;
			end
			FORM_BIN: begin
				if (d == 0 || d == 1) add_digit(d, 2, value_mask());
				else lx_form = FORM_REJECT;
			end
			FORM_REAL: begin
				if (c >= CharZero && c <= CharNine) lx_digit = 1;
				else if (c == CharMinus && lx_pos == 2'd1) lx_minus = 1;
				else if (c == CharPoint && !lx_point) lx_point = 1;
				else if (c == CharExp && !lx_exp) lx_exp = 1;
				else if ((c == CharMinus || c == CharPlus) && lx_exp && !lx_exp_sign)
					lx_exp_sign = 1;
				else lx_form = FORM_REJECT;
			end
			default: lx_form = FORM_REJECT;
		endcase
		if (lx_pos < 2'd3) lx_pos = lx_pos + 2'd1;

		has_lit = fin;
		lit.kind = KIND_NAN;
		lit.value = 64'd0;
		if (!fin) return;
		if (lx_digit) begin
			case (lx_form)
				FORM_REAL: lit.kind = KIND_REAL;
				FORM_HEX, FORM_BIN: begin
					if (lx_big) lit.kind = KIND_RANGE;
					else begin
						lit.kind = KIND_INT;
						lit.value = lx_mag & value_mask();
					end
				end
				FORM_DEC: begin
					if (lx_big || (!lx_minus && lx_mag > dec_limit - 64'd1)) lit.kind = KIND_RANGE;
					else begin
						lit.kind = KIND_INT;
						lit.value = (lx_minus ? 64'd0 - lx_mag : lx_mag) & value_mask();
					end
				end
				default: ;
			endcase
		end
		clear_lexer();
	endtask

	// Offer one character, wait for the request to be taken, then predict.
	task automatic send_char(input logic [7:0] c, input logic fin,
			output bit has_lit, output literal_t lit);
		int gap;
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.token_char <= c;
		chars_if.last_char <= fin;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		classify_char(c, fin, has_lit, lit);
		chars_sent++;
	endtask

	task automatic put_byte(logic [7:0] b);
		tok_bytes = {tok_bytes, b};
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_digits(int n, int base);
		int v;
		for (int i = 0; i < n; i++) begin
			v = $urandom_range(0, base - 1);
			if (v < 10) put_byte(CharZero + 8'(v));
			else if ($urandom_range(0, 1)) put_byte(CharLowA + 8'(v - 10));
			else put_byte(CharUpA + 8'(v - 10));
		end
	endtask

	task automatic build_integer(int base);
		bit lengthy;
		lengthy = $urandom_range(0, 9) < 2;
		case (base)
			10: begin
				put_byte(CharDec);
				if ($urandom_range(0, 2) == 0) put_byte(CharMinus);
				put_digits(lengthy ? $urandom_range(17, 20) : $urandom_range(1, 5), 10);
			end
			16: begin
				put_byte(CharHex);
				put_digits(lengthy ? $urandom_range(14, 17) : $urandom_range(1, 4), 16);
			end
			default: begin
				put_byte(CharBin);
				// long binary runs are kept rare
				put_digits($urandom_range(0, 9) == 0 ? $urandom_range(60, 66)
					: $urandom_range(1, 12), 2);
			end
		endcase
	endtask

	task automatic build_real();
		put_byte(CharReal);
		if ($urandom_range(0, 2) == 0) put_byte(CharMinus);
		put_digits($urandom_range(0, 3), 10);
		if ($urandom_range(0, 1)) put_byte(CharPoint);
		put_digits($urandom_range(0, 3), 10);
		if ($urandom_range(0, 1)) begin
			put_byte(CharExp);
			put_digits($urandom_range(0, 2), 10);
			if ($urandom_range(0, 1))
				put_byte($urandom_range(0, 1) ? CharPlus : CharMinus);
			put_digits($urandom_range(0, 2), 10);
		end
	endtask

	// Values at and just past the edges of the integer ranges.
	task automatic build_boundary();
		logic [63:0] v;
		case ($urandom_range(0, 4))
			0: begin
				put_byte(CharDec);
				if ($urandom_range(0, 1)) put_byte(CharMinus);
				v = 64'h7fff_ffff_ffff_ffff + 64'($urandom_range(0, 2));
				put_text($sformatf("%0d", v));
			end
			1: begin
				put_byte(CharDec);
				if ($urandom_range(0, 1)) put_byte(CharMinus);
				put_text($urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616");
			end
			2: begin
				put_byte(CharHex);
				if ($urandom_range(0, 2) == 0) put_text("10000000000000000");
				else begin
					put_text("ffffffffffffffff");
					if ($urandom_range(0, 1)) put_digits(1, 16);
				end
			end
			3: begin
				put_byte(CharBin);
				for (int i = 0; i < 64; i++) put_byte(CharOne);
				if ($urandom_range(0, 1)) put_digits(1, 2);
			end
			default: begin
				put_byte(CharDec);
				if ($urandom_range(0, 1)) put_byte(CharMinus);
				put_digits($urandom_range(1, 3), 1);
			end
		endcase
	endtask

	task automatic build_plain(int which);
		case (which)
			0: build_integer(10);
			1: build_integer(16);
			2: build_integer(2);
			default: build_real();
		endcase
	endtask

	task automatic build_token();
		int r;
		int at;
		logic [7:0] marks [6];
		marks = '{CharMinus, CharPlus, CharPoint, CharExp, CharDec, CharUpA};
		tok_bytes.delete();
		r = $urandom_range(0, 99);
		if (r < 22) build_plain(0);
		else if (r < 40) build_plain(1);
		else if (r < 55) build_plain(2);
		else if (r < 72) build_plain(3);
		else if (r < 82) build_boundary();
		else begin
			build_plain($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: begin
					tok_bytes.delete();
					repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
				end
				1: begin
					at = $urandom_range(0, tok_bytes.size() - 1);
					tok_bytes[at] = 8'($urandom_range(0, 255));
				end
				2: begin
					at = $urandom_range(1, tok_bytes.size());
					tok_bytes.insert(at, marks[$urandom_range(0, 5)]);
				end
				default: tok_bytes = tok_bytes[0:0];
			endcase
		end
	endtask

	task automatic check_result();
		literal_t want;
		if (pending_literals.size() == 0) begin
			$error("unexpected result: literal_kind %0d integer_value %h",
				results_if.literal_kind, results_if.integer_value);
			mismatch_count++;
			return;
		end
		want = pending_literals.pop_front();
		if (results_if.literal_kind !== want.kind) begin
			$error("literal_kind: expected %0d, got %0d", want.kind, results_if.literal_kind);
			mismatch_count++;
		end
		if (results_if.integer_value !== want.value) begin
			$error("integer_value: expected %h, got %h", want.value, results_if.integer_value);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("prefixed_number_literal_recognizer_top_test: done, errors");
		$finish;
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) check_result();
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				if (!quiet_phase && $urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	initial begin
		bit has_lit;
		bit pressure_done;
		literal_t lit;
		literal_t typed_lit;
		pressure_done = 0;
		clear_lexer();
		arst_n <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.token_char <= 8'h00;
		chars_if.last_char <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			for (int i = 0; i < dir_rows[r].len; i++) begin
				send_char(dir_rows[r].text[8 * (dir_rows[r].len - 1 - i) +: 8],
					i == dir_rows[r].len - 1, has_lit, lit);
				if (has_lit) begin
					typed_lit.kind = dir_rows[r].kind;
					typed_lit.value = dir_rows[r].value;
					pending_literals = {pending_literals,
						(dir_rows[r].given ? typed_lit : lit)};
				end
			end
		end

		while (chars_sent < CHAR_TARGET) begin
			if ($urandom_range(0, 29) == 0) quiet_phase = !quiet_phase;
			if (!pressure_done && chars_sent >= CHAR_TARGET / 2) begin
				long_hold_req = 1;
				pressure_done = 1;
			end
			build_token();
			foreach (tok_bytes[i]) begin
				send_char(tok_bytes[i], i == tok_bytes.size() - 1, has_lit, lit);
				if (has_lit) pending_literals = {pending_literals, lit};
			end
		end
		chars_if.valid <= 1'b0;

		while (pending_literals.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("prefixed_number_literal_recognizer_top_test: done, clean");
		else
			$display("prefixed_number_literal_recognizer_top_test: done, errors");
		$finish;
	end

endmodule
